// File: rtl/ltdc_pkg.sv
// Shared types and constants of the load tuning deadband controller.
// Holds the command and status structs that join controller and datapath.
// No dependencies; the datapath, controller and top level refer to it by scoped names.
package ltdc_pkg;

	// Field widths fixed by the item format.
	localparam int VOLT_W = 13;
	localparam int SAMPLE_W = 14;
	localparam int WIPER_W = 9;
	localparam int RES_W = 20;
	localparam int PWR_W = 32;
	localparam int CNT_W = 32;
	localparam int CFG_W = 13;

	// Shared divider sizes: the widest numerator is v*v*10^6, the widest
	// denominator is r1 + 10^6.
	localparam int DIV_NUM_W = 46;
	localparam int DIV_DEN_W = 21;

	// Fixed point widths of the calibration quadratic (24 fraction bits).
	localparam int Q_W = 52;
	localparam int A_W = 26;
	localparam int B_W = 35;

	// Model constants.
	localparam logic [WIPER_W-1:0] HI_START = 9'd232;
	localparam logic [9:0] HI_SPAN = 10'd488;
	localparam int ONE_MILLION = 1000000;
	localparam int R_HI_SCALE = 94300;

	// Quadratic coefficients in Q24, rounded to nearest.
	localparam logic signed [A_W-1:0] LO_A = 26'sd20590174;
	localparam logic signed [B_W-1:0] LO_B = -35'sd7128382387;
	localparam logic signed [Q_W-1:0] LO_C = 52'sd468368867983;
	localparam logic signed [A_W-1:0] HI_A = 26'sd169279;
	localparam logic signed [B_W-1:0] HI_B = -35'sd9909141;
	localparam logic signed [Q_W-1:0] HI_C = -52'sd36709857231;

	// Register reset values.
	localparam logic [12:0] TARGET_RST = 13'd1800;
	localparam logic [9:0] BAND_RST = 10'd50;
	localparam logic [9:0] SDIV_RST = 10'd50;
	localparam logic [12:0] THR_RST = 13'd2000;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_TARGET = 2'd0,
		CFG_BAND = 2'd1,
		CFG_SDIV = 2'd2,
		CFG_THR = 2'd3
	} cfg_idx_t;

	// Datapath commands issued by the controller.
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_MUL1,
		CMD_MUL2,
		CMD_BASE,
		CMD_QUAD,
		CMD_RES,
		CMD_PWR,
		CMD_FIN
	} cmd_t;

	// Operand selection for the shared divider.
	typedef enum logic [1:0] {
		DIV_BASE,
		DIV_PWR,
		DIV_STEP
	} div_sel_t;

	typedef struct packed {
		cmd_t cmd;
		logic div_start;
		div_sel_t div_sel;
	} ctrl_t;

	typedef struct packed {
		logic op_load;
		logic is_hi;
		logic need_step;
		logic div_busy;
	} status_t;

endpackage

// File: rtl/ltdc_in_if.sv
// Input channel of the controller: valid/ready handshake and item payload.
// Depends on nothing.
interface ltdc_in_if;
	logic valid;
	logic ready;
	logic op;
	logic signed [13:0] sample_mv;
	logic [8:0] wiper_value;

	modport source(output valid, output op, output sample_mv, output wiper_value, input ready);
	modport sink(input valid, input op, input sample_mv, input wiper_value, output ready);
endinterface

// File: rtl/ltdc_out_if.sv
// Result channel of the controller: valid/ready handshake and result payload.
// Depends on nothing.
interface ltdc_out_if;
	logic valid;
	logic ready;
	logic [12:0] voltage_mv;
	logic [19:0] resistance_ohm;
	logic [31:0] power_pw;
	logic [8:0] wiper;
	logic [31:0] above_count;
	logic [12:0] peak_mv;

	modport source(output valid, output voltage_mv, output resistance_ohm, output power_pw,
		output wiper, output above_count, output peak_mv, input ready);
	modport sink(input valid, input voltage_mv, input resistance_ohm, input power_pw,
		input wiper, input above_count, input peak_mv, output ready);
endinterface

// File: rtl/ltdc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; shared by the datapath for all three divisions.
module ltdc_div #(
	parameter int NUM_W = 46,
	parameter int DEN_W = 21
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic busy,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0] trial;
	logic take;

	// Bring down the next numerator bit and try the subtraction.
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign take = trial >= {1'b0, den_q};

	// Control: busy from a start until the counter, loaded with NUM_W, runs down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and shifting numerator/quotient word.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quo = quo_q;

	// A start always opens a busy period.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");

	// The unit never becomes busy without a start.
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && !start) |=> (!busy_q || $past(start)))
		else $error("divider became busy without a start");

	// The partial remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && den_q != '0) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

endmodule

// File: rtl/ltdc_datapath.sv
// Datapath: configuration and state registers, multipliers, quadratic,
// deadband logic and the shared divider. Depends on ltdc_pkg and ltdc_div.
module ltdc_datapath #(
	parameter int WIPER_MAX = 487
) (
	input logic clk,
	input logic arst_n,
	input ltdc_pkg::ctrl_t ctrl,
	output ltdc_pkg::status_t status,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [ltdc_pkg::CFG_W-1:0] cfg_wdata,
	input logic in_op,
	input logic signed [13:0] in_sample_mv,
	input logic [8:0] in_wiper_value,
	output logic [12:0] voltage_mv,
	output logic [19:0] resistance_ohm,
	output logic [31:0] power_pw,
	output logic [8:0] wiper,
	output logic [31:0] above_count,
	output logic [12:0] peak_mv
);

	localparam logic [8:0] WMAX = 9'(WIPER_MAX);
	localparam int QW = ltdc_pkg::Q_W;
	localparam int NW = ltdc_pkg::DIV_NUM_W;
	localparam int DW = ltdc_pkg::DIV_DEN_W;

	// Configuration registers.
	logic [12:0] target_q;
	logic [9:0] band_q;
	logic [9:0] sdiv_q;
	logic [12:0] thr_q;

	// Architectural state.
	logic [8:0] wiper_q;
	logic [31:0] count_q;
	logic [12:0] peak_q;
	logic [12:0] last_q;

	// Working registers of one item.
	logic op_q;
	logic [8:0] wv_q;
	logic [12:0] v_q;
	logic [25:0] vv_q;
	logic [17:0] pp_q;
	logic signed [QW-1:0] bp_q;
	logic [19:0] base_lo_q;
	logic [17:0] r1_q;
	logic [45:0] pnum_q;
	logic signed [QW-1:0] ap_q;
	logic [37:0] bnum_q;
	logic [20:0] bden_q;
	logic [19:0] base_q;
	logic signed [QW-1:0] quad_q;
	logic [19:0] res_q;
	logic [31:0] pwr_q;

	// Result registers.
	logic [12:0] o_volt_q;
	logic [19:0] o_res_q;
	logic [31:0] o_pwr_q;
	logic [8:0] o_wiper_q;
	logic [31:0] o_cnt_q;
	logic [12:0] o_peak_q;

	// Combinational terms.
	logic is_hi;
	logic signed [ltdc_pkg::A_W-1:0] coef_a;
	logic signed [ltdc_pkg::B_W-1:0] coef_b;
	logic signed [QW-1:0] coef_c;
	logic signed [ltdc_pkg::B_W+9:0] bp_full;
	logic signed [ltdc_pkg::A_W+18:0] ap_full;
	logic [8:0] lo_fac;
	logic [28:0] blo_prod;
	logic [9:0] hi_fac;
	logic [26:0] r1_prod;
	logic signed [QW-1:0] rq;
	logic [13:0] upper;
	logic [12:0] lower;
	logic go_up;
	logic go_dn;
	logic [13:0] step_num;
	logic [9:0] sdiv_eff;
	logic [13:0] step;
	logic [14:0] up_sum;
	logic [8:0] wiper_step;
	logic [31:0] cnt_next;
	logic [12:0] peak_next;
	logic [8:0] wv_sat;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic div_busy;
	logic [NW-1:0] div_quo;

	// Segment selection and coefficients of the resistance model.
	assign is_hi = wiper_q >= ltdc_pkg::HI_START;
	assign coef_a = is_hi ? ltdc_pkg::HI_A : ltdc_pkg::LO_A;
	assign coef_b = is_hi ? ltdc_pkg::HI_B : ltdc_pkg::LO_B;
	assign coef_c = is_hi ? ltdc_pkg::HI_C : ltdc_pkg::LO_C;

	assign bp_full = coef_b * $signed({1'b0, wiper_q});
	assign ap_full = coef_a * $signed({1'b0, pp_q});
	assign lo_fac = 9'd256 - wiper_q;
	assign blo_prod = {20'd0, lo_fac} * 29'(ltdc_pkg::ONE_MILLION);
	assign hi_fac = ({1'b0, wiper_q} <= ltdc_pkg::HI_SPAN) ?
		(ltdc_pkg::HI_SPAN - {1'b0, wiper_q}) : 10'd0;
	assign r1_prod = {17'd0, hi_fac} * 27'(ltdc_pkg::R_HI_SCALE);

	// Fixed point resistance before truncation.
	assign rq = $signed({8'd0, base_q, 24'd0}) - quad_q;

	// Deadband limits and step numerator.
	assign upper = {1'b0, target_q} + {4'd0, band_q};
	assign lower = (target_q >= {3'd0, band_q}) ? (target_q - {3'd0, band_q}) : 13'd0;
	assign go_up = {1'b0, v_q} > upper;
	assign go_dn = v_q < lower;
	assign step_num = go_up ? ({1'b0, v_q} - upper) : {1'b0, lower - v_q};
	assign sdiv_eff = (sdiv_q == 10'd0) ? 10'd1 : sdiv_q;

	// New wiper position after a deadband step of at least one.
	assign step = (div_quo[13:0] == 14'd0) ? 14'd1 : div_quo[13:0];
	assign up_sum = {6'd0, wiper_q} + {1'b0, step};
	always_comb begin
		wiper_step = wiper_q;
		if (go_up) begin
			wiper_step = (up_sum >= 15'(WIPER_MAX)) ? WMAX : up_sum[8:0];
		end else if (go_dn) begin
			wiper_step = ({5'd0, wiper_q} <= step) ? 9'd0 : (wiper_q - step[8:0]);
		end
	end

	// Count and peak, cleared while the wiper sits at zero.
	always_comb begin
		cnt_next = (v_q > thr_q) ? (count_q + 32'd1) : count_q;
		peak_next = (peak_q < v_q) ? v_q : peak_q;
		if (wiper_q == 9'd0) begin
			cnt_next = '0;
			peak_next = '0;
		end
	end

	assign wv_sat = (wv_q > WMAX) ? WMAX : wv_q;

	// Divider operand selection.
	always_comb begin
		case (ctrl.div_sel)
			ltdc_pkg::DIV_BASE: begin
				div_num = {8'd0, bnum_q};
				div_den = bden_q;
			end
			ltdc_pkg::DIV_PWR: begin
				div_num = pnum_q;
				div_den = {1'b0, res_q};
			end
			ltdc_pkg::DIV_STEP: begin
				div_num = {32'd0, step_num};
				div_den = {11'd0, sdiv_eff};
			end
			default: begin
				div_num = pnum_q;
				div_den = {1'b0, res_q};
			end
		endcase
	end

	ltdc_div #(
		.NUM_W(NW),
		.DEN_W(DW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(ctrl.div_start),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.quo(div_quo)
	);

	// Configuration and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ltdc_pkg::TARGET_RST;
			band_q <= ltdc_pkg::BAND_RST;
			sdiv_q <= ltdc_pkg::SDIV_RST;
			thr_q <= ltdc_pkg::THR_RST;
			wiper_q <= '0;
			count_q <= '0;
			peak_q <= '0;
			last_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					ltdc_pkg::CFG_TARGET: target_q <= cfg_wdata;
					ltdc_pkg::CFG_BAND: band_q <= cfg_wdata[9:0];
					ltdc_pkg::CFG_SDIV: sdiv_q <= cfg_wdata[9:0];
					ltdc_pkg::CFG_THR: thr_q <= cfg_wdata;
					default: target_q <= target_q;
				endcase
			end
			if (ctrl.cmd == ltdc_pkg::CMD_FIN) begin
				if (op_q) begin
					wiper_q <= wv_sat;
				end else begin
					wiper_q <= wiper_step;
					count_q <= cnt_next;
					peak_q <= peak_next;
					last_q <= v_q;
				end
			end
		end
	end

	// Working and result registers, stepped by command.
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			ltdc_pkg::CMD_CAPTURE: begin
				op_q <= in_op;
				wv_q <= in_wiper_value;
				v_q <= in_sample_mv[13] ? 13'd0 : in_sample_mv[12:0];
			end
			ltdc_pkg::CMD_MUL1: begin
				vv_q <= {13'd0, v_q} * {13'd0, v_q};
				pp_q <= {9'd0, wiper_q} * {9'd0, wiper_q};
				bp_q <= QW'(bp_full);
				base_lo_q <= blo_prod[27:8];
				r1_q <= r1_prod[25:8];
			end
			ltdc_pkg::CMD_MUL2: begin
				pnum_q <= {20'd0, vv_q} * 46'(ltdc_pkg::ONE_MILLION);
				ap_q <= QW'(ap_full);
				bnum_q <= {20'd0, r1_q} * 38'(ltdc_pkg::ONE_MILLION);
				bden_q <= {3'd0, r1_q} + 21'(ltdc_pkg::ONE_MILLION);
			end
			ltdc_pkg::CMD_BASE: begin
				base_q <= is_hi ? div_quo[19:0] : base_lo_q;
			end
			ltdc_pkg::CMD_QUAD: begin
				quad_q <= ap_q + bp_q + coef_c;
			end
			ltdc_pkg::CMD_RES: begin
				// Non-positive values clamp to zero; large values saturate.
				if (rq[QW-1] || rq == '0) begin
					res_q <= '0;
				end else if (|rq[QW-1:44]) begin
					res_q <= '1;
				end else begin
					res_q <= rq[43:24];
				end
			end
			ltdc_pkg::CMD_PWR: begin
				if (res_q == '0 || (|div_quo[45:32])) begin
					pwr_q <= '1;
				end else begin
					pwr_q <= div_quo[31:0];
				end
			end
			ltdc_pkg::CMD_FIN: begin
				if (op_q) begin
					o_volt_q <= last_q;
					o_res_q <= '0;
					o_pwr_q <= '0;
					o_wiper_q <= wv_sat;
					o_cnt_q <= count_q;
					o_peak_q <= peak_q;
				end else begin
					o_volt_q <= v_q;
					o_res_q <= res_q;
					o_pwr_q <= pwr_q;
					o_wiper_q <= wiper_step;
					o_cnt_q <= cnt_next;
					o_peak_q <= peak_next;
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign status.op_load = op_q;
	assign status.is_hi = is_hi;
	assign status.need_step = go_up | go_dn;
	assign status.div_busy = div_busy;

	assign voltage_mv = o_volt_q;
	assign resistance_ohm = o_res_q;
	assign power_pw = o_pwr_q;
	assign wiper = o_wiper_q;
	assign above_count = o_cnt_q;
	assign peak_mv = o_peak_q;

	// The wiper never leaves its range.
	a_wiper_range: assert property (@(posedge clk) disable iff (!arst_n)
		wiper_q <= WMAX)
		else $error("wiper position above its maximum");

	// A sample taken with the wiper at zero leaves count and peak cleared.
	a_zero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cmd == ltdc_pkg::CMD_FIN && !op_q && wiper_q == 9'd0)
		|=> (count_q == '0 && peak_q == '0))
		else $error("count or peak not cleared at zero wiper");

	// Commands that read the divider never arrive while it is busy.
	a_div_read: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cmd == ltdc_pkg::CMD_BASE || ctrl.cmd == ltdc_pkg::CMD_PWR
		|| ctrl.cmd == ltdc_pkg::CMD_FIN) |-> !div_busy)
		else $error("divider result read while busy");

endmodule

// File: rtl/ltdc_ctrl.sv
// Controller: sequences the datapath for one item and owns the handshakes.
// Depends on ltdc_pkg.
module ltdc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input ltdc_pkg::status_t status,
	output ltdc_pkg::ctrl_t ctrl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_BDIV,
		S_BWAIT,
		S_BASE,
		S_QUAD,
		S_RES,
		S_PDIV,
		S_PWAIT,
		S_PWR,
		S_SDIV,
		S_SWAIT,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic fin_ok;

	// A result may be written once the output register is free or drains.
	assign fin_ok = !out_valid_q || out_ready;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		ctrl.cmd = ltdc_pkg::CMD_NONE;
		ctrl.div_start = 1'b0;
		ctrl.div_sel = ltdc_pkg::DIV_BASE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.cmd = ltdc_pkg::CMD_CAPTURE;
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				if (status.op_load) begin
					state_d = S_FIN;
				end else begin
					ctrl.cmd = ltdc_pkg::CMD_MUL1;
					state_d = S_MUL2;
				end
			end
			S_MUL2: begin
				ctrl.cmd = ltdc_pkg::CMD_MUL2;
				state_d = status.is_hi ? S_BDIV : S_BASE;
			end
			S_BDIV: begin
				ctrl.div_start = 1'b1;
				ctrl.div_sel = ltdc_pkg::DIV_BASE;
				state_d = S_BWAIT;
			end
			S_BWAIT: begin
				ctrl.div_sel = ltdc_pkg::DIV_BASE;
				if (!status.div_busy) begin
					state_d = S_BASE;
				end
			end
			S_BASE: begin
				ctrl.cmd = ltdc_pkg::CMD_BASE;
				state_d = S_QUAD;
			end
			S_QUAD: begin
				ctrl.cmd = ltdc_pkg::CMD_QUAD;
				state_d = S_RES;
			end
			S_RES: begin
				ctrl.cmd = ltdc_pkg::CMD_RES;
				state_d = S_PDIV;
			end
			S_PDIV: begin
				ctrl.div_start = 1'b1;
				ctrl.div_sel = ltdc_pkg::DIV_PWR;
				state_d = S_PWAIT;
			end
			S_PWAIT: begin
				ctrl.div_sel = ltdc_pkg::DIV_PWR;
				if (!status.div_busy) begin
					state_d = S_PWR;
				end
			end
			S_PWR: begin
				ctrl.cmd = ltdc_pkg::CMD_PWR;
				state_d = status.need_step ? S_SDIV : S_FIN;
			end
			S_SDIV: begin
				ctrl.div_start = 1'b1;
				ctrl.div_sel = ltdc_pkg::DIV_STEP;
				state_d = S_SWAIT;
			end
			S_SWAIT: begin
				ctrl.div_sel = ltdc_pkg::DIV_STEP;
				if (!status.div_busy) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_ok) begin
					ctrl.cmd = ltdc_pkg::CMD_FIN;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.cmd == ltdc_pkg::CMD_FIN) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// The divider is only started when it is free.
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.div_start |-> !status.div_busy)
		else $error("divider started while busy");

	// Finishing an item always presents a result.
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cmd == ltdc_pkg::CMD_FIN) |=> out_valid_q)
		else $error("finished item not presented");

	// A pending result is never overwritten before its transfer.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cmd == ltdc_pkg::CMD_FIN) |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

endmodule

// File: rtl/load_tuning_deadband_controller_unit.sv
// Sequence: a wiper load is captured and goes straight to the result register. A sample
// runs the multiplies, base, quadratic, resistance and power steps; the power always takes
// a divider pass, the base one when the wiper is at 232 or above, and the step one when the
// voltage is outside the deadband; all use the shared bit-serial divider (46 bits, one a cycle).
// Throughput: one item at a time; the next is taken while a result waits.
// Reset (arst_n, asynchronous): configuration registers to their defaults, state to zero.
module load_tuning_deadband_controller_unit #(
	parameter int WIPER_MAX = 487
) (
	input logic clk,
	input logic arst_n,
	ltdc_in_if.sink items,
	ltdc_out_if.source results,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [ltdc_pkg::CFG_W-1:0] cfg_wdata
);

	ltdc_pkg::ctrl_t ctrl;
	ltdc_pkg::status_t status;

	// Sequencer.
	ltdc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(items.valid),
		.in_ready(items.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.status(status),
		.ctrl(ctrl)
	);

	// Arithmetic and state.
	ltdc_datapath #(
		.WIPER_MAX(WIPER_MAX)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_op(items.op),
		.in_sample_mv(items.sample_mv),
		.in_wiper_value(items.wiper_value),
		.voltage_mv(results.voltage_mv),
		.resistance_ohm(results.resistance_ohm),
		.power_pw(results.power_pw),
		.wiper(results.wiper),
		.above_count(results.above_count),
		.peak_mv(results.peak_mv)
	);

endmodule
